// ===== sv/mffr_pkg.sv =====
// mffr_pkg: shared constants, command codes and controller/datapath structs
// for the maze flood-fill router. No dependencies; compiled first.

package mffr_pkg;

  localparam int unsigned GRID_SIDE_DEFAULT = 16;

  localparam int unsigned COORD_W     = 4;
  localparam int unsigned DIST_W      = 8;
  localparam int unsigned WALL_BITS_W = 4;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned DIR_W       = 2;

  // command modes
  localparam logic [MODE_W-1:0] MODE_WALL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // headings, also the bit position of the matching wall flag
  localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
  localparam logic [DIR_W-1:0] DIR_EAST  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
  localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

  localparam logic [WALL_BITS_W-1:0] WBIT_N = 4'd1;
  localparam logic [WALL_BITS_W-1:0] WBIT_E = 4'd2;
  localparam logic [WALL_BITS_W-1:0] WBIT_S = 4'd4;
  localparam logic [WALL_BITS_W-1:0] WBIT_W = 4'd8;

  localparam logic [DIST_W-1:0] DIST_UNREACHED = 8'hFF;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic cell_from_in;
    logic cell_from_q;
    logic sweep_reset;
    logic sweep_step;
    logic sweep_walls;
    logic sweep_dist;
    logic addr_nbr;
    logic latch_cell;
    logic k_clear;
    logic k_step;
    logic wall_wr_self;
    logic wall_wr_nbr;
    logic seed_chk;
    logic relax;
    logic q_reset;
    logic q_pop;
    logic best_init;
    logic best_chk;
    logic set_seeding;
    logic clr_seeding;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              on_grid;
    logic              last;
    logic              seeding;
    logic              nbr_ok;
    logic              nbr_open;
    logic              mask_hit;
    logic              k_last;
    logic              sweep_last;
    logic              q_more;
  } dp_status_t;

endpackage

// ===== sv/mffr_ram.sv =====
// mffr_ram: generic single-write, single-read RAM with registered read data.
// Standalone; used for the wall, distance and queue stores.

module mffr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mffr_dpath.sv =====
// mffr_dpath: cell/neighbor addressing, the three stores, queue pointers and
// query result registers. Depends on mffr_pkg and mffr_ram.

module mffr_dpath #(
  parameter int unsigned GRID_SIDE = mffr_pkg::GRID_SIDE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mffr_pkg::MODE_W-1:0]         mode,
  input  logic [mffr_pkg::COORD_W-1:0]        x,
  input  logic [mffr_pkg::COORD_W-1:0]        y,
  input  logic [mffr_pkg::WALL_BITS_W-1:0]    wall_mask,
  input  logic [mffr_pkg::DIR_W-1:0]          facing,
  input  logic                                seed_last,
  input  mffr_pkg::ctrl_cmd_t                 cmd,
  output mffr_pkg::dp_status_t                status,
  output logic [mffr_pkg::DIST_W-1:0]         distance,
  output logic [mffr_pkg::WALL_BITS_W-1:0]    cell_walls,
  output logic                                has_wall,
  output logic [mffr_pkg::DIR_W-1:0]          best_direction
);

  import mffr_pkg::*;

  localparam int unsigned CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int unsigned IDX_W  = $clog2(CELLS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned EXT_W  = COORD_W + 1;
  localparam int unsigned SUM_W  = 2 * COORD_W;
  localparam int unsigned QENT_W = 2 * COORD_W;
  localparam int unsigned DEXT_W = DIST_W + 1;

  localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(GRID_SIDE - 1);
  localparam logic [EXT_W-1:0]   SIDE_EXT   = EXT_W'(GRID_SIDE);
  localparam logic [CNT_W-1:0]   QUEUE_CAP  = CNT_W'(CELLS);

  function automatic logic [IDX_W-1:0] cell_of(input logic [COORD_W-1:0] cx_i,
                                               input logic [COORD_W-1:0] cy_i);
    logic [SUM_W-1:0] lin;
    lin = SUM_W'(cx_i) * SUM_W'(GRID_SIDE) + SUM_W'(cy_i);
    return lin[IDX_W-1:0];
  endfunction

  // latched command fields
  logic [MODE_W-1:0]      mode_r;
  logic [COORD_W-1:0]     in_x;
  logic [COORD_W-1:0]     in_y;
  logic [WALL_BITS_W-1:0] mask_r;
  logic [DIR_W-1:0]       facing_r;
  logic                   last_r;

  // working cell, neighbor counter, queue pointers
  logic [COORD_W-1:0]     cx;
  logic [COORD_W-1:0]     cy;
  logic [DIR_W-1:0]       k;
  logic [CNT_W-1:0]       head;
  logic [CNT_W-1:0]       tail;
  logic                   seeding;

  logic [WALL_BITS_W-1:0] cur_walls;
  logic [DIST_W-1:0]      cur_dist;
  logic [DIST_W-1:0]      best_dist;
  logic [DIR_W-1:0]       best_dir;

  logic [COORD_W-1:0]     nx;
  logic [COORD_W-1:0]     ny;
  logic                   nbr_ok;
  logic [WALL_BITS_W-1:0] k_bit;
  logic [WALL_BITS_W-1:0] opp_bit;
  logic [IDX_W-1:0]       cidx;
  logic [IDX_W-1:0]       nidx;
  logic                   on_grid;

  logic                   wall_we;
  logic [IDX_W-1:0]       wall_waddr;
  logic [WALL_BITS_W-1:0] wall_wdata;
  logic [IDX_W-1:0]       rd_addr;
  logic [WALL_BITS_W-1:0] wall_rdata;
  logic [WALL_BITS_W-1:0] boundary;

  logic                   dist_we;
  logic [IDX_W-1:0]       dist_waddr;
  logic [DIST_W-1:0]      dist_wdata;
  logic [DIST_W-1:0]      dist_rdata;
  logic [DEXT_W-1:0]      d_plus;
  logic                   relax_hit;
  logic                   seed_hit;

  logic                   q_room;
  logic                   q_we;
  logic [QENT_W-1:0]      q_wdata;
  logic [QENT_W-1:0]      q_rdata;

  // neighbor of the working cell in direction k
  always_comb begin
    nx     = cx;
    ny     = cy;
    nbr_ok = 1'b0;
    unique case (k)
      DIR_NORTH: begin
        ny     = cy + COORD_W'(1);
        nbr_ok = (EXT_W'(cy) + EXT_W'(1)) < SIDE_EXT;
      end
      DIR_EAST: begin
        nx     = cx + COORD_W'(1);
        nbr_ok = (EXT_W'(cx) + EXT_W'(1)) < SIDE_EXT;
      end
      DIR_SOUTH: begin
        ny     = cy - COORD_W'(1);
        nbr_ok = (cy != '0);
      end
      DIR_WEST: begin
        nx     = cx - COORD_W'(1);
        nbr_ok = (cx != '0);
      end
      default: begin
        nbr_ok = 1'b0;
      end
    endcase
  end

  assign k_bit   = WALL_BITS_W'(1) << k;
  assign opp_bit = WALL_BITS_W'(1) << (k ^ DIR_SOUTH);
  assign cidx    = cell_of(cx, cy);
  assign nidx    = cell_of(nx, ny);
  assign rd_addr = cmd.addr_nbr ? nidx : cidx;
  assign on_grid = (EXT_W'(in_x) < SIDE_EXT) && (EXT_W'(in_y) < SIDE_EXT);

  // outer walls for the sweep cell
  assign boundary = ((cy == '0)         ? WBIT_S : '0)
                  | ((cy == LAST_COORD) ? WBIT_N : '0)
                  | ((cx == '0)         ? WBIT_W : '0)
                  | ((cx == LAST_COORD) ? WBIT_E : '0);

  // wall store
  assign wall_we    = cmd.sweep_walls | cmd.wall_wr_self | cmd.wall_wr_nbr;
  assign wall_waddr = cmd.wall_wr_nbr ? nidx : cidx;
  always_comb begin
    priority if (cmd.sweep_walls) begin
      wall_wdata = boundary;
    end else if (cmd.wall_wr_self) begin
      wall_wdata = wall_rdata | mask_r;
    end else begin
      wall_wdata = wall_rdata | opp_bit;
    end
  end

  mffr_ram #(.WIDTH(WALL_BITS_W), .DEPTH(CELLS)) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (wall_waddr),
    .wdata (wall_wdata),
    .raddr (rd_addr),
    .rdata (wall_rdata)
  );

  // distance store
  assign d_plus    = DEXT_W'(cur_dist) + DEXT_W'(1);
  assign relax_hit = DEXT_W'(dist_rdata) > d_plus;
  assign seed_hit  = (dist_rdata != '0);
  assign dist_we   = cmd.sweep_dist | (cmd.seed_chk & seed_hit) | (cmd.relax & relax_hit);
  assign dist_waddr = cmd.relax ? nidx : cidx;
  always_comb begin
    priority if (cmd.sweep_dist) begin
      dist_wdata = DIST_UNREACHED;
    end else if (cmd.seed_chk) begin
      dist_wdata = '0;
    end else begin
      dist_wdata = d_plus[DIST_W-1:0];
    end
  end

  mffr_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (rd_addr),
    .rdata (dist_rdata)
  );

  // cell queue, entries hold packed coordinates
  assign q_room  = tail < QUEUE_CAP;
  assign q_we    = q_room & ((cmd.seed_chk & seed_hit) | (cmd.relax & relax_hit));
  assign q_wdata = cmd.relax ? {nx, ny} : {cx, cy};

  mffr_ram #(.WIDTH(QENT_W), .DEPTH(CELLS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail[IDX_W-1:0]),
    .wdata (q_wdata),
    .raddr (head[IDX_W-1:0]),
    .rdata (q_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cx      <= '0;
      cy      <= '0;
      k       <= '0;
      head    <= '0;
      tail    <= '0;
      seeding <= 1'b0;
    end else begin
      priority if (cmd.sweep_reset) begin
        cx <= '0;
        cy <= '0;
      end else if (cmd.cell_from_in) begin
        cx <= in_x;
        cy <= in_y;
      end else if (cmd.cell_from_q) begin
        cx <= q_rdata[QENT_W-1:COORD_W];
        cy <= q_rdata[COORD_W-1:0];
      end else if (cmd.sweep_step) begin
        if (cy == LAST_COORD) begin
          cy <= '0;
          cx <= cx + COORD_W'(1);
        end else begin
          cy <= cy + COORD_W'(1);
        end
      end

      if (cmd.k_clear) begin
        k <= '0;
      end else if (cmd.k_step) begin
        k <= k + DIR_W'(1);
      end

      if (cmd.q_reset) begin
        head <= '0;
        tail <= '0;
      end else begin
        if (cmd.q_pop) begin
          head <= head + CNT_W'(1);
        end
        if (q_we) begin
          tail <= tail + CNT_W'(1);
        end
      end

      if (cmd.set_seeding) begin
        seeding <= 1'b1;
      end else if (cmd.clr_seeding) begin
        seeding <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r   <= mode;
      in_x     <= x;
      in_y     <= y;
      mask_r   <= wall_mask;
      facing_r <= facing;
      last_r   <= seed_last;
    end
    if (cmd.latch_cell) begin
      cur_walls <= wall_rdata;
      cur_dist  <= dist_rdata;
    end
    if (cmd.best_init) begin
      best_dist <= DIST_UNREACHED;
      best_dir  <= facing_r;
    end else if (cmd.best_chk && (dist_rdata < best_dist)) begin
      best_dist <= dist_rdata;
      best_dir  <= k;
    end
  end

  always_comb begin
    status            = '0;
    status.mode       = mode_r;
    status.on_grid    = on_grid;
    status.last       = last_r;
    status.seeding    = seeding;
    status.nbr_ok     = nbr_ok;
    status.nbr_open   = ((cur_walls & k_bit) == '0);
    status.mask_hit   = ((mask_r & k_bit) != '0);
    status.k_last     = (k == DIR_WEST);
    status.sweep_last = (cx == LAST_COORD) && (cy == LAST_COORD);
    status.q_more     = head < tail;
  end

  // result fields, only a query reports anything
  always_comb begin
    distance       = '0;
    cell_walls     = '0;
    has_wall       = 1'b0;
    best_direction = '0;
    if (mode_r == MODE_QUERY) begin
      if (on_grid) begin
        distance       = cur_dist;
        cell_walls     = cur_walls;
        has_wall       = ((cur_walls & mask_r) != '0);
        best_direction = best_dir;
      end else begin
        distance       = DIST_UNREACHED;
        best_direction = facing_r;
      end
    end
  end

endmodule

// ===== sv/mffr_ctrl.sv =====
// mffr_ctrl: sequencing state machine for clear, wall update, seed, flood
// and query commands. Depends on mffr_pkg.

module mffr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output mffr_pkg::ctrl_cmd_t  cmd,
  input  mffr_pkg::dp_status_t status
);

  import mffr_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_CLR      = 5'd2;
  localparam logic [4:0] S_DCLR     = 5'd3;
  localparam logic [4:0] S_WU_RD    = 5'd4;
  localparam logic [4:0] S_WU_WR    = 5'd5;
  localparam logic [4:0] S_WU_NRD   = 5'd6;
  localparam logic [4:0] S_WU_NWR   = 5'd7;
  localparam logic [4:0] S_SD_RD    = 5'd8;
  localparam logic [4:0] S_SD_CHK   = 5'd9;
  localparam logic [4:0] S_SD_END   = 5'd10;
  localparam logic [4:0] S_FL_POP   = 5'd11;
  localparam logic [4:0] S_FL_LD    = 5'd12;
  localparam logic [4:0] S_FL_RD    = 5'd13;
  localparam logic [4:0] S_FL_CW    = 5'd14;
  localparam logic [4:0] S_FL_NRD   = 5'd15;
  localparam logic [4:0] S_FL_NCK   = 5'd16;
  localparam logic [4:0] S_Q_RD     = 5'd17;
  localparam logic [4:0] S_Q_CW     = 5'd18;
  localparam logic [4:0] S_Q_NRD    = 5'd19;
  localparam logic [4:0] S_Q_NCK    = 5'd20;
  localparam logic [4:0] S_RESULT   = 5'd21;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_IDLE) && start) begin
        pending <= 1'b1;
      end else if (state == S_RESULT) begin
        pending <= 1'b0;
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.mode)
          MODE_CLEAR: begin
            cmd.sweep_reset = 1'b1;
            cmd.q_reset     = 1'b1;
            cmd.clr_seeding = 1'b1;
            state_next      = S_CLR;
          end
          MODE_WALL: begin
            if (status.on_grid) begin
              cmd.cell_from_in = 1'b1;
              state_next       = S_WU_RD;
            end else begin
              state_next = S_RESULT;
            end
          end
          MODE_SEED: begin
            if (!status.seeding) begin
              cmd.sweep_reset = 1'b1;
              cmd.q_reset     = 1'b1;
              cmd.set_seeding = 1'b1;
              state_next      = S_DCLR;
            end else begin
              cmd.cell_from_in = 1'b1;
              state_next       = S_SD_RD;
            end
          end
          MODE_QUERY: begin
            if (status.on_grid) begin
              cmd.cell_from_in = 1'b1;
              state_next       = S_Q_RD;
            end else begin
              state_next = S_RESULT;
            end
          end
          default: begin
            state_next = S_RESULT;
          end
        endcase
      end
      S_CLR: begin
        cmd.sweep_walls = 1'b1;
        cmd.sweep_dist  = 1'b1;
        if (status.sweep_last) begin
          state_next = pending ? S_RESULT : S_IDLE;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_DCLR: begin
        cmd.sweep_dist = 1'b1;
        if (status.sweep_last) begin
          cmd.cell_from_in = 1'b1;
          state_next       = S_SD_RD;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_WU_RD: begin
        state_next = S_WU_WR;
      end
      S_WU_WR: begin
        cmd.wall_wr_self = 1'b1;
        cmd.k_clear      = 1'b1;
        state_next       = S_WU_NRD;
      end
      S_WU_NRD: begin
        if (status.mask_hit && status.nbr_ok) begin
          cmd.addr_nbr = 1'b1;
          state_next   = S_WU_NWR;
        end else if (status.k_last) begin
          state_next = S_RESULT;
        end else begin
          cmd.k_step = 1'b1;
        end
      end
      S_WU_NWR: begin
        cmd.wall_wr_nbr = 1'b1;
        if (status.k_last) begin
          state_next = S_RESULT;
        end else begin
          cmd.k_step = 1'b1;
          state_next = S_WU_NRD;
        end
      end
      S_SD_RD: begin
        state_next = status.on_grid ? S_SD_CHK : S_SD_END;
      end
      S_SD_CHK: begin
        cmd.seed_chk = 1'b1;
        state_next   = S_SD_END;
      end
      S_SD_END: begin
        if (status.last) begin
          cmd.clr_seeding = 1'b1;
          state_next      = S_FL_POP;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_FL_POP: begin
        state_next = status.q_more ? S_FL_LD : S_RESULT;
      end
      S_FL_LD: begin
        cmd.cell_from_q = 1'b1;
        cmd.q_pop       = 1'b1;
        state_next      = S_FL_RD;
      end
      S_FL_RD: begin
        state_next = S_FL_CW;
      end
      S_FL_CW: begin
        cmd.latch_cell = 1'b1;
        cmd.k_clear    = 1'b1;
        state_next     = S_FL_NRD;
      end
      S_FL_NRD: begin
        if (status.nbr_ok && status.nbr_open) begin
          cmd.addr_nbr = 1'b1;
          state_next   = S_FL_NCK;
        end else if (status.k_last) begin
          state_next = S_FL_POP;
        end else begin
          cmd.k_step = 1'b1;
        end
      end
      S_FL_NCK: begin
        cmd.relax = 1'b1;
        if (status.k_last) begin
          state_next = S_FL_POP;
        end else begin
          cmd.k_step = 1'b1;
          state_next = S_FL_NRD;
        end
      end
      S_Q_RD: begin
        cmd.best_init = 1'b1;
        state_next    = S_Q_CW;
      end
      S_Q_CW: begin
        cmd.latch_cell = 1'b1;
        cmd.k_clear    = 1'b1;
        state_next     = S_Q_NRD;
      end
      S_Q_NRD: begin
        if (status.nbr_ok && status.nbr_open) begin
          cmd.addr_nbr = 1'b1;
          state_next   = S_Q_NCK;
        end else if (status.k_last) begin
          state_next = S_RESULT;
        end else begin
          cmd.k_step = 1'b1;
        end
      end
      S_Q_NCK: begin
        cmd.best_chk = 1'b1;
        if (status.k_last) begin
          state_next = S_RESULT;
        end else begin
          cmd.k_step = 1'b1;
          state_next = S_Q_NRD;
        end
      end
      S_RESULT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/maze_flood_fill_router_top.sv =====
// maze_flood_fill_router_top: top level of the maze flood-fill router.
// Depends on mffr_pkg, mffr_ram, mffr_dpath and mffr_ctrl.

// A command is taken when start is high and busy is low; every command
// produces exactly one result, shown on the result ports for one cycle with
// done high, and the receiver cannot stall it, so sample on done. busy stays
// high from the transfer of a command through its done cycle. Only a query
// carries data; other commands return all-zero fields. A wall update writes
// the cell and then each neighbor that takes the facing wall; a query reads
// the distance of each open neighbor; either goes straight to its result when
// the cell is off the grid. A clear sweeps every cell, and the first seed of
// a run first sweeps every distance. A seed marked last then runs the flood,
// which reads each queued cell and each of its open in-grid neighbors in
// turn. The timing comes from the single registered read port on each store:
// every cell or neighbor look-up is one read and the flood visits them one at
// a time. After reset the block holds busy high while it writes the boundary
// walls and unreachable distances into the stores.

module maze_flood_fill_router_top #(
  parameter int unsigned GRID_SIDE = mffr_pkg::GRID_SIDE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mffr_pkg::MODE_W-1:0]      mode,
  input  logic [mffr_pkg::COORD_W-1:0]     x,
  input  logic [mffr_pkg::COORD_W-1:0]     y,
  input  logic [mffr_pkg::WALL_BITS_W-1:0] wall_mask,
  input  logic [mffr_pkg::DIR_W-1:0]       facing,
  input  logic                             seed_last,
  output logic                             done,
  output logic [mffr_pkg::DIST_W-1:0]      distance,
  output logic [mffr_pkg::WALL_BITS_W-1:0] cell_walls,
  output logic                             has_wall,
  output logic [mffr_pkg::DIR_W-1:0]       best_direction
);

  import mffr_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  mffr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  mffr_dpath #(.GRID_SIDE(GRID_SIDE)) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .mode           (mode),
    .x              (x),
    .y              (y),
    .wall_mask      (wall_mask),
    .facing         (facing),
    .seed_last      (seed_last),
    .cmd            (cmd),
    .status         (status),
    .distance       (distance),
    .cell_walls     (cell_walls),
    .has_wall       (has_wall),
    .best_direction (best_direction)
  );

  // result strobe comes straight from the result state
  assign done = cmd.emit;

  // one result per command, never two back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted command always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

  // only queries report data
  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    (done && (status.mode != MODE_QUERY)) |->
      ((distance == '0) && (cell_walls == '0) && !has_wall && (best_direction == '0)))
    else $error("non-query result carries data");

  // the last seed closes the seeding run before its result
  a_seed_closed: assert property (@(posedge clk) disable iff (rst)
    (done && (status.mode == MODE_SEED) && status.last) |-> !status.seeding)
    else $error("seeding still open after last seed");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for maze_flood_fill_router_top
// depends on mffr_pkg and the router rtl; keeps its own maze and flood model

module tb;
  import mffr_pkg::*;

  localparam int SIDE          = 16;
  localparam int NUM_CMDS      = 540;
  localparam int IDLE_LIMIT    = 20000;  // watchdog limit, well above the worst flood
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS   = 20;

  // one command as the sender offers it; drain makes the sender wait for
  // every outstanding answer and then sit idle for a while
  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [WALL_BITS_W-1:0] mask;
    logic [DIR_W-1:0]       facing;
    logic                   last;
    logic                   drain;
  } cmd_t;

  // one answer of the router
  typedef struct packed {
    logic [DIST_W-1:0]      depth;
    logic [WALL_BITS_W-1:0] walls;
    logic                   hit;
    logic [DIR_W-1:0]       heading;
  } answer_t;

  // dut ports, all inputs known from time zero
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic [MODE_W-1:0]      mode      = '0;
  logic [COORD_W-1:0]     x         = '0;
  logic [COORD_W-1:0]     y         = '0;
  logic [WALL_BITS_W-1:0] wall_mask = '0;
  logic [DIR_W-1:0]       facing    = '0;
  logic                   seed_last = 1'b0;
  logic                   busy;
  logic                   done;
  logic [DIST_W-1:0]      distance;
  logic [WALL_BITS_W-1:0] cell_walls;
  logic                   has_wall;
  logic [DIR_W-1:0]       best_direction;

  maze_flood_fill_router_top #(.GRID_SIDE(SIDE)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .x(x),
    .y(y),
    .wall_mask(wall_mask),
    .facing(facing),
    .seed_last(seed_last),
    .done(done),
    .distance(distance),
    .cell_walls(cell_walls),
    .has_wall(has_wall),
    .best_direction(best_direction)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // maze model: wall marks, flood distances and the flood work list
  // ---------------------------------------------------------------------
  logic [WALL_BITS_W-1:0] wall_map [256];
  logic [DIST_W-1:0]      dist_map [256];
  logic [7:0]             flood_q  [256];
  int                     q_head, q_tail;
  bit                     seeding;

  // cells are stored column-major, x * SIDE + y
  function automatic int cell_of(input int cx, input int cy);
    return (cx * SIDE + cy) & 255;
  endfunction

  // neighbor toward heading k; returns 0 when it falls off the grid
  function automatic bit next_cell(input int cx, input int cy, input int k, output int n);
    int nx, ny;
    nx = cx + ((k == int'(DIR_EAST)) ? 1 : (k == int'(DIR_WEST)) ? -1 : 0);
    ny = cy + ((k == int'(DIR_NORTH)) ? 1 : (k == int'(DIR_SOUTH)) ? -1 : 0);
    n = cell_of(nx, ny);
    return nx >= 0 && ny >= 0 && nx < SIDE && ny < SIDE;
  endfunction

  function automatic void clear_distances();
    for (int i = 0; i < 256; i++) dist_map[i] = DIST_UNREACHED;
    q_head = 0;
    q_tail = 0;
  endfunction

  // boundary walls only, everything unreachable, no seeding run open
  function automatic void maze_reset();
    for (int i = 0; i < 256; i++) wall_map[i] = '0;
    for (int i = 0; i < SIDE; i++) begin
      wall_map[cell_of(i, 0)]        |= WBIT_S;
      wall_map[cell_of(i, SIDE - 1)] |= WBIT_N;
      wall_map[cell_of(0, i)]        |= WBIT_W;
      wall_map[cell_of(SIDE - 1, i)] |= WBIT_E;
    end
    clear_distances();
    seeding = 1'b0;
  endfunction

  function automatic void enqueue(input int n);
    if (q_tail < 256) begin
      flood_q[q_tail] = 8'(n);
      q_tail++;
    end
  endfunction

  // breadth-first pass; a neighbor is taken only if it gets strictly closer,
  // so a cell at 254 never spreads and 255 stays unreachable
  function automatic void flood_fill();
    int idx, nd, n;
    while (q_head < q_tail && q_head < 256) begin
      idx = flood_q[q_head];
      nd  = dist_map[idx] + 1;
      q_head++;
      for (int k = 0; k < 4; k++)
        if (!wall_map[idx][k] && next_cell(idx / SIDE, idx % SIDE, k, n))
          if (dist_map[n] > nd) begin
            dist_map[n] = 8'(nd);
            enqueue(n);
          end
    end
  endfunction

  // applies one command to the model and returns the router's answer
  function automatic answer_t router_answer(input cmd_t c);
    answer_t a;
    int      idx, n, best;
    bit      on_grid;
    a       = '0;
    on_grid = c.x < SIDE && c.y < SIDE;
    idx     = cell_of(c.x, c.y);
    case (c.mode)
      MODE_WALL: begin
        if (on_grid) begin
          wall_map[idx] |= c.mask;
          // the facing side sits two headings away
          for (int k = 0; k < 4; k++)
            if (c.mask[k] && next_cell(c.x, c.y, k, n))
              wall_map[n] |= 4'(1) << ((k + 2) % 4);
        end
      end
      MODE_SEED: begin
        if (!seeding) begin
          clear_distances();
          seeding = 1'b1;
        end
        if (on_grid && dist_map[idx] != '0) begin
          dist_map[idx] = '0;
          enqueue(idx);
        end
        if (c.last) begin
          flood_fill();
          seeding = 1'b0;
        end
      end
      MODE_QUERY: begin
        a.heading = c.facing;
        if (!on_grid) begin
          a.depth = DIST_UNREACHED;
        end else begin
          best = DIST_UNREACHED;
          for (int k = 0; k < 4; k++)
            if (!wall_map[idx][k] && next_cell(c.x, c.y, k, n))
              if (dist_map[n] < best) begin
                best      = dist_map[n];
                a.heading = 2'(k);
              end
          a.depth = dist_map[idx];
          a.walls = wall_map[idx];
          a.hit   = |(wall_map[idx] & c.mask);
        end
      end
      default: maze_reset();
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus list
  // ---------------------------------------------------------------------
  cmd_t pending [$];

  task automatic add_cmd(input logic [MODE_W-1:0] m, input int cx, input int cy,
                         input int msk, input int face, input bit lst, input bit hold);
    cmd_t c;
    c.mode   = m;
    c.x      = 4'(cx);
    c.y      = 4'(cy);
    c.mask   = 4'(msk);
    c.facing = 2'(face);
    c.last   = lst;
    c.drain  = hold;
    pending.push_back(c);
  endtask

  // coordinates lean toward the border rows and columns
  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return SIDE - 1;
      default: return $urandom_range(0, SIDE - 1);
    endcase
  endfunction

  // single walls half the time so the maze does not close up too fast
  function automatic int rand_mask();
    if ($urandom_range(0, 1) == 0) return 1 << $urandom_range(0, 3);
    return $urandom_range(0, 15);
  endfunction

  function automatic bit rand_hold();
    return $urandom_range(0, 39) == 0;
  endfunction

  task automatic add_scenario();
    int pick, n, cx, cy;
    pick = $urandom_range(0, 19);
    if (pick < 6) begin
      // build some walls
      n = $urandom_range(2, 8);
      repeat (n) add_cmd(MODE_WALL, rand_coord(), rand_coord(), rand_mask(),
                         $urandom_range(0, 3), 1'($urandom_range(0, 1)), rand_hold());
    end else if (pick < 11) begin
      // goal run: a few seeds, now and then a repeat, queries while seeding
      n  = $urandom_range(1, 4);
      cx = rand_coord();
      cy = rand_coord();
      for (int i = 0; i < n; i++) begin
        if (i != 0 && $urandom_range(0, 3) != 0) begin
          cx = rand_coord();
          cy = rand_coord();
        end
        if (i != 0 && $urandom_range(0, 2) == 0)
          add_cmd(MODE_QUERY, rand_coord(), rand_coord(), rand_mask(),
                  $urandom_range(0, 3), 1'($urandom_range(0, 1)), rand_hold());
        add_cmd(MODE_SEED, cx, cy, $urandom_range(0, 15), $urandom_range(0, 3),
                i == n - 1, rand_hold());
      end
    end else if (pick < 17) begin
      n = $urandom_range(2, 8);
      repeat (n) add_cmd(MODE_QUERY, rand_coord(), rand_coord(), $urandom_range(0, 15),
                         $urandom_range(0, 3), 1'($urandom_range(0, 1)), rand_hold());
    end else if (pick == 17) begin
      add_cmd(MODE_CLEAR, rand_coord(), rand_coord(), $urandom_range(0, 15),
              $urandom_range(0, 3), 1'($urandom_range(0, 1)), rand_hold());
    end else begin
      // noise: any mode, any fields, possibly leaving a seeding run open
      n = $urandom_range(1, 4);
      repeat (n) add_cmd(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 3), 1'($urandom_range(0, 1)), rand_hold());
    end
  endtask

  // ---------------------------------------------------------------------
  // driver: offers commands in bursts and folds each transfer into the model
  // ---------------------------------------------------------------------
  answer_t    answer_ring [256];
  logic [7:0] answers_in  = '0;
  logic [7:0] answers_out = '0;

  cmd_t    shown;
  answer_t predicted;
  bit      fire;
  bit      drained    = 1'b0;
  int      burst_left = 4;
  int      gap_left   = 0;
  int      hold_left  = 0;
  int      n_cmds = 0, n_wall = 0, n_seed = 0, n_flood = 0, n_query = 0, n_clear = 0;
  int      far_depth  = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      maze_reset();
    end else begin
      fire = start && !busy;
      if (fire) begin
        predicted = router_answer(shown);
        answer_ring[answers_in] <= predicted;
        answers_in <= answers_in + 8'd1;
        n_cmds++;
        case (shown.mode)
          MODE_WALL:  n_wall++;
          MODE_SEED: begin
            n_seed++;
            if (shown.last) n_flood++;
          end
          MODE_QUERY: begin
            n_query++;
            if (predicted.depth != DIST_UNREACHED && predicted.depth > far_depth)
              far_depth = predicted.depth;
          end
          default:    n_clear++;
        endcase
        // end of a burst: draw the next gap, sometimes none at all
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      // a command still on offer stays put until busy lets it through
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending.size() == 0) begin
          start <= 1'b0;
        end else if (pending[0].drain && !drained) begin
          // wait for every answer, then hold off a little longer
          start <= 1'b0;
          if (!fire && answers_out == answers_in) begin
            drained   = 1'b1;
            hold_left = $urandom_range(5, 40);
          end
        end else if (hold_left > 0) begin
          hold_left--;
          start <= 1'b0;
        end else begin
          shown   = pending.pop_front();
          drained = 1'b0;
          start     <= 1'b1;
          mode      <= shown.mode;
          x         <= shown.x;
          y         <= shown.y;
          wall_mask <= shown.mask;
          facing    <= shown.facing;
          seed_last <= shown.last;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: every done is matched against the oldest predicted answer
  // ---------------------------------------------------------------------
  answer_t want;
  int      mismatches = 0;
  int      n_results  = 0;

  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (answers_out == answers_in) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: answer arrived with no command outstanding", $time);
      end else begin
        want = answer_ring[answers_out];
        answers_out <= answers_out + 8'd1;
        if (distance !== want.depth || cell_walls !== want.walls ||
            has_wall !== want.hit || best_direction !== want.heading) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected distance %0d walls %h has_wall %0d best_direction %0d",
                     $time, want.depth, want.walls, want.hit, want.heading);
            $display("%0t:   actual distance %0d walls %h has_wall %0d best_direction %0d",
                     $time, distance, cell_walls, has_wall, best_direction);
          end
        end
      end
    end
  end

  // watchdog: a run with no transfer and no answer for too long is hung
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer and no answer for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // command list, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    // fresh maze: corners and borders
    add_cmd(MODE_QUERY, 0, 0, WBIT_N | WBIT_E | WBIT_S | WBIT_W, DIR_NORTH, 0, 0);
    add_cmd(MODE_QUERY, SIDE - 1, SIDE - 1, 0, DIR_WEST, 0, 0);
    add_cmd(MODE_QUERY, SIDE - 1, 0, WBIT_N, DIR_SOUTH, 1, 0);
    // walls, including masks that point off the grid
    add_cmd(MODE_WALL, 0, 0, WBIT_N | WBIT_E | WBIT_S | WBIT_W, DIR_EAST, 0, 0);
    add_cmd(MODE_WALL, SIDE - 1, SIDE - 1, WBIT_N | WBIT_E | WBIT_S | WBIT_W,
            DIR_WEST, 1, 0);
    add_cmd(MODE_WALL, 7, 8, WBIT_N | WBIT_S, DIR_NORTH, 0, 0);
    add_cmd(MODE_WALL, 7, 8, 0, DIR_SOUTH, 0, 0);
    add_cmd(MODE_QUERY, 7, 8, WBIT_E, DIR_EAST, 0, 0);
    add_cmd(MODE_QUERY, 7, 9, WBIT_S, DIR_WEST, 0, 0);
    // seed run on two cells, with a repeat and queries while it is open
    add_cmd(MODE_SEED, 3, 4, 0, DIR_NORTH, 0, 0);
    add_cmd(MODE_QUERY, 3, 4, WBIT_W, DIR_NORTH, 0, 0);
    add_cmd(MODE_QUERY, 3, 5, 0, DIR_SOUTH, 0, 0);
    add_cmd(MODE_SEED, 3, 4, 0, DIR_EAST, 0, 0);
    add_cmd(MODE_SEED, 12, 2, 0, DIR_SOUTH, 1, 0);
    add_cmd(MODE_QUERY, 3, 5, 0, DIR_EAST, 0, 0);
    add_cmd(MODE_QUERY, 8, 8, WBIT_W, DIR_WEST, 0, 0);
    // single-seed run on the walled-in corner, sender drains first
    add_cmd(MODE_SEED, 0, 0, 0, DIR_NORTH, 1, 1);
    add_cmd(MODE_QUERY, 0, 1, 0, DIR_NORTH, 0, 0);
    // clear with every field at its top value
    add_cmd(MODE_CLEAR, SIDE - 1, SIDE - 1, WBIT_N | WBIT_E | WBIT_S | WBIT_W,
            DIR_WEST, 1, 0);
    add_cmd(MODE_QUERY, 0, 1, 0, DIR_NORTH, 0, 0);
    // open maze: one seed floods every cell, the work list fills completely
    add_cmd(MODE_SEED, 9, 6, 0, DIR_NORTH, 1, 0);
    add_cmd(MODE_QUERY, 0, SIDE - 1, WBIT_N | WBIT_E | WBIT_S | WBIT_W,
            DIR_SOUTH, 0, 0);
    add_cmd(MODE_QUERY, SIDE - 1, SIDE - 1, 0, DIR_EAST, 0, 0);
    add_cmd(MODE_WALL, SIDE - 1, 0, WBIT_E | WBIT_W, DIR_WEST, 1, 0);
    add_cmd(MODE_QUERY, 9, 6, 0, DIR_WEST, 1, 0);

    // serpentine maze: one path through all cells so the far end saturates
    add_cmd(MODE_CLEAR, 0, 0, 0, DIR_NORTH, 0, 0);
    for (int cx = 1; cx < SIDE; cx += 2)
      for (int cy = 0; cy < SIDE; cy++)
        add_cmd(MODE_WALL, cx, cy,
                ((cy != SIDE - 1) ? WBIT_W : 0) |
                ((cx + 1 < SIDE && cy != 0) ? WBIT_E : 0),
                $urandom_range(0, 3), 1'($urandom_range(0, 1)), 0);
    add_cmd(MODE_SEED, 0, 0, $urandom_range(0, 15), $urandom_range(0, 3), 1, 0);
    add_cmd(MODE_QUERY, SIDE - 1, 0, $urandom_range(0, 15), $urandom_range(0, 3), 0, 0);
    add_cmd(MODE_QUERY, SIDE - 1, 1, $urandom_range(0, 15), $urandom_range(0, 3), 0, 0);
    add_cmd(MODE_QUERY, SIDE - 1, 2, $urandom_range(0, 15), $urandom_range(0, 3), 0, 0);
    add_cmd(MODE_QUERY, 8, 8, $urandom_range(0, 15), $urandom_range(0, 3), 0, 0);
    add_cmd(MODE_QUERY, 0, 0, $urandom_range(0, 15), $urandom_range(0, 3), 0, 0);

    // random mix of wall building, goal runs, queries, clears and noise
    while (pending.size() < NUM_CMDS) add_scenario();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all commands through and all answers back, then watch for strays
    do @(negedge clk);
    while (pending.size() != 0 || start || answers_in != answers_out);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d commands: %0d wall updates, %0d seeds, %0d floods, %0d queries, %0d clears",
             n_cmds, n_wall, n_seed, n_flood, n_query, n_clear);
    $display("checked %0d answers, farthest reachable distance %0d, %0d mismatches",
             n_results, far_depth, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== maze_flood_fill_router_top.f =====
sv/mffr_pkg.sv
sv/mffr_ram.sv
sv/mffr_dpath.sv
sv/mffr_ctrl.sv
sv/maze_flood_fill_router_top.sv
sim/tb.sv
